FILE: design/rde_pkg.sv
// rde_pkg: shared constants, command codes and types of the raster draw engine
// no dependencies; imported by every design file of the block
package rde_pkg;

    localparam int MAX_WIDTH  = 64;
    localparam int MAX_HEIGHT = 64;
    localparam int FRAC_BITS  = 16;

    localparam int X_BITS    = $clog2(MAX_WIDTH);
    localparam int Y_BITS    = $clog2(MAX_HEIGHT);
    localparam int ADDR_BITS = X_BITS + Y_BITS;
    localparam int MEM_DEPTH = MAX_WIDTH * MAX_HEIGHT;

    localparam int DIM_W   = 7;
    localparam int COORD_W = 16;
    localparam int COLOR_W = 32;
    localparam int REQ_W   = 3;
    localparam int CFG_IDX_W = 1;

    // line stepping widths
    localparam int LEN_W = COORD_W;
    localparam int DVD_W = LEN_W + FRAC_BITS;
    localparam int QUO_W = FRAC_BITS + 1;
    localparam int INC_W = FRAC_BITS + 2;
    localparam int POS_W = COORD_W + FRAC_BITS + 2;
    localparam int RND_W = POS_W - FRAC_BITS;

    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic [DIM_W-1:0] MAX_W_DIM = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] MAX_H_DIM = DIM_W'(MAX_HEIGHT);

    localparam logic signed [INC_W-1:0] INC_ONE = {2'b01, {FRAC_BITS{1'b0}}};
    localparam logic signed [POS_W-1:0] POS_HALF = POS_W'(1) << (FRAC_BITS - 1);
    localparam logic signed [POS_W-1:0] POS_HALF_M1 = POS_HALF - POS_W'(1);

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 1'b1;

    // request codes on the input channel
    localparam logic [REQ_W-1:0] REQ_CLEAR = 3'd0;
    localparam logic [REQ_W-1:0] REQ_PIXEL = 3'd1;
    localparam logic [REQ_W-1:0] REQ_LINE  = 3'd2;
    localparam logic [REQ_W-1:0] REQ_RECT  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_GRID  = 3'd4;
    localparam logic [REQ_W-1:0] REQ_TRI   = 3'd5;
    localparam logic [REQ_W-1:0] REQ_READ  = 3'd6;

    typedef enum logic [2:0] {
        OP_NOP   = 3'd0,
        OP_CLEAR = 3'd1,
        OP_PIXEL = 3'd2,
        OP_LINE  = 3'd3,
        OP_RECT  = 3'd4,
        OP_GRID  = 3'd5,
        OP_TRI   = 3'd6,
        OP_READ  = 3'd7
    } rde_op_t;

    typedef struct packed {
        rde_op_t                    op;
        logic [COLOR_W-1:0]         color;
        logic signed [COORD_W-1:0]  ax;
        logic signed [COORD_W-1:0]  ay;
        logic signed [COORD_W-1:0]  bx;
        logic signed [COORD_W-1:0]  by;
        logic signed [COORD_W-1:0]  cx;
        logic signed [COORD_W-1:0]  cy;
    } rde_cmd_t;

endpackage

FILE: design/rde_front.sv
// rde_front: accepts request words, decodes the request type into an op
// and buffers commands in a short queue; uses rde_pkg
module rde_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           req_valid,
    output logic                           req_stall,
    input  logic [rde_pkg::REQ_W-1:0]      req_type,
    input  logic [rde_pkg::COLOR_W-1:0]    color,
    input  logic signed [rde_pkg::COORD_W-1:0] ax,
    input  logic signed [rde_pkg::COORD_W-1:0] ay,
    input  logic signed [rde_pkg::COORD_W-1:0] bx,
    input  logic signed [rde_pkg::COORD_W-1:0] by,
    input  logic signed [rde_pkg::COORD_W-1:0] cx,
    input  logic signed [rde_pkg::COORD_W-1:0] cy,
    output rde_pkg::rde_cmd_t              q_head,
    output logic                           q_valid,
    input  logic                           q_pop
);
    import rde_pkg::*;

    rde_cmd_t            q_mem [QDEPTH];
    logic [QPTR_W-1:0]   wr_ptr_reg;
    logic [QPTR_W-1:0]   rd_ptr_reg;
    logic [QCNT_W-1:0]   count_reg;
    rde_op_t             op;
    rde_cmd_t            cmd_in;
    logic                push;

    always_comb
    begin
        unique case (req_type)
            REQ_CLEAR: op = OP_CLEAR;
            REQ_PIXEL: op = OP_PIXEL;
            REQ_LINE:  op = OP_LINE;
            REQ_RECT:  op = OP_RECT;
            REQ_GRID:  op = OP_GRID;
            REQ_TRI:   op = OP_TRI;
            REQ_READ:  op = OP_READ;
            default:   op = OP_NOP;
        endcase
    end

    always_comb
    begin
        cmd_in.op    = op;
        cmd_in.color = color;
        cmd_in.ax    = ax;
        cmd_in.ay    = ay;
        cmd_in.bx    = bx;
        cmd_in.by    = by;
        cmd_in.cx    = cx;
        cmd_in.cy    = cy;
    end

    assign req_stall = (count_reg == QCNT_W'(QDEPTH));
    assign push      = req_valid && !req_stall;
    assign q_valid   = (count_reg != '0);
    assign q_head    = q_mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= cmd_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (q_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
            if (push && !q_pop)
            begin
                count_reg <= count_reg + QCNT_W'(1);
            end
            else if (!push && q_pop)
            begin
                count_reg <= count_reg - QCNT_W'(1);
            end
        end
    end

endmodule

FILE: design/rde_div.sv
// rde_div: restoring divider, one quotient bit per cycle, for the minor-axis
// step of a line; uses rde_pkg
module rde_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [rde_pkg::DVD_W-1:0]     dividend,
    input  logic [rde_pkg::LEN_W-1:0]     divisor,
    output logic                          done,
    output logic [rde_pkg::QUO_W-1:0]     quotient
);
    import rde_pkg::*;

    localparam int STEP_W = $clog2(DVD_W);

    logic                busy_reg;
    logic                done_reg;
    logic [STEP_W-1:0]   step_reg;
    logic [DVD_W-1:0]    acc_reg;
    logic [LEN_W:0]      rem_reg;
    logic [LEN_W-1:0]    dsr_reg;
    logic [LEN_W:0]      shifted;
    logic [LEN_W+1:0]    diff;
    logic                neg;

    assign shifted  = {rem_reg[LEN_W-1:0], acc_reg[DVD_W-1]};
    assign diff     = {1'b0, shifted} - {2'b00, dsr_reg};
    assign neg      = diff[LEN_W+1];
    assign done     = done_reg;
    assign quotient = acc_reg[QUO_W-1:0];

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            acc_reg <= {acc_reg[DVD_W-2:0], !neg};
            rem_reg <= neg ? shifted : diff[LEN_W:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '0;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg + STEP_W'(1);
                if (step_reg == STEP_W'(DVD_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

`ifndef ASSERT_OFF
    a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !busy_reg)
        else $error("divider started while busy");
`endif

endmodule

FILE: design/rde_back.sv
// rde_back: executes queued commands against the frame store (clears, pixels, lines,
// triangles, rectangles, grids, reads) and holds the result register; uses rde_pkg, rde_div
module rde_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  rde_pkg::rde_cmd_t             q_head,
    input  logic                          q_valid,
    output logic                          q_pop,
    input  logic [rde_pkg::DIM_W-1:0]     width_in_use,
    input  logic [rde_pkg::DIM_W-1:0]     height_in_use,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [rde_pkg::COLOR_W-1:0]   read_color,
    output logic                          in_range
);
    import rde_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_DISP  = 8'b0000_0010,
        S_LSET  = 8'b0000_0100,
        S_LDIV  = 8'b0000_1000,
        S_LDRAW = 8'b0001_0000,
        S_SCAN  = 8'b0010_0000,
        S_RDW   = 8'b0100_0000,
        S_DONE  = 8'b1000_0000
    } state_t;

    state_t                     state_reg;
    rde_cmd_t                   cmd_reg;
    logic [1:0]                 seg_reg;

    // area scan
    logic [DIM_W-1:0]           cur_x_reg, cur_y_reg, xs_reg, xe_reg, ye_reg;
    logic                       grid_reg;
    logic [LEN_W-1:0]           gx_reg, gy_reg, xi_reg, yi_reg;

    // line stepping
    logic signed [POS_W-1:0]    px_reg, py_reg;
    logic signed [INC_W-1:0]    ix_reg, iy_reg;
    logic [LEN_W-1:0]           cnt_reg;
    logic                       xmaj_reg, mneg_reg;

    // results
    logic [COLOR_W-1:0]         res_color_reg;
    logic                       res_in_range_reg;
    logic                       out_valid_reg;
    logic [COLOR_W-1:0]         out_color_reg;
    logic                       out_in_range_reg;

    // frame store
    logic [COLOR_W-1:0]         mem [MEM_DEPTH];
    logic [COLOR_W-1:0]         rd_data_reg;
    logic                       mem_we;
    logic [DIM_W-1:0]           wr_x, wr_y;
    logic [ADDR_BITS-1:0]       wr_addr, rd_addr;
    logic                       rd_en;

    logic [DIM_W-1:0]           aw, ah;
    logic signed [COORD_W-1:0]  x0, y0, x1, y1;
    logic signed [COORD_W:0]    dx, dy;
    logic [LEN_W-1:0]           adx, ady, len;
    logic                       xmaj;
    logic                       div_start, div_done;
    logic [QUO_W-1:0]           div_q;
    logic signed [INC_W-1:0]    minor_inc;

    logic signed [POS_W-1:0]    sum_x, sum_y;
    logic signed [RND_W-1:0]    rx, ry;
    logic                       line_in;

    logic                       a_in;
    logic [DIM_W-1:0]           b_xs, b_xe, b_ys, b_ye;
    logic                       b_empty;
    logic signed [COORD_W:0]    xend, yend;
    logic [LEN_W-1:0]           abs_bx, abs_by;

    logic                       grid_hit, scan_we, row_end, scan_last;
    logic                       out_load;

    assign aw = (width_in_use  > MAX_W_DIM) ? MAX_W_DIM : width_in_use;
    assign ah = (height_in_use > MAX_H_DIM) ? MAX_H_DIM : height_in_use;

    // endpoints of the current line segment
    always_comb
    begin
        case (seg_reg)
            2'd1:
            begin
                x0 = cmd_reg.bx; y0 = cmd_reg.by; x1 = cmd_reg.cx; y1 = cmd_reg.cy;
            end
            2'd2:
            begin
                x0 = cmd_reg.cx; y0 = cmd_reg.cy; x1 = cmd_reg.ax; y1 = cmd_reg.ay;
            end
            default:
            begin
                x0 = cmd_reg.ax; y0 = cmd_reg.ay; x1 = cmd_reg.bx; y1 = cmd_reg.by;
            end
        endcase
    end

    assign dx   = {x1[COORD_W-1], x1} - {x0[COORD_W-1], x0};
    assign dy   = {y1[COORD_W-1], y1} - {y0[COORD_W-1], y0};
    assign adx  = LEN_W'(dx[COORD_W] ? -dx : dx);
    assign ady  = LEN_W'(dy[COORD_W] ? -dy : dy);
    assign xmaj = (adx >= ady);
    assign len  = xmaj ? adx : ady;

    assign div_start = (state_reg == S_LSET) && (len != '0);

    rde_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend ({(xmaj ? ady : adx), {FRAC_BITS{1'b0}}}),
        .divisor  (len),
        .done     (div_done),
        .quotient (div_q)
    );

    assign minor_inc = mneg_reg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});

    // round half away from zero: floor((p + half - (p < 0)) / one)
    assign sum_x   = px_reg + (px_reg[POS_W-1] ? POS_HALF_M1 : POS_HALF);
    assign sum_y   = py_reg + (py_reg[POS_W-1] ? POS_HALF_M1 : POS_HALF);
    assign rx      = sum_x[POS_W-1:FRAC_BITS];
    assign ry      = sum_y[POS_W-1:FRAC_BITS];
    assign line_in = !rx[RND_W-1] && (rx[RND_W-2:0] < (RND_W-1)'(aw))
                  && !ry[RND_W-1] && (ry[RND_W-2:0] < (RND_W-1)'(ah));

    // single point inside test, for pixel and read
    assign a_in = !cmd_reg.ax[COORD_W-1]
               && (cmd_reg.ax[COORD_W-2:0] < (COORD_W-1)'(aw))
               && !cmd_reg.ay[COORD_W-1]
               && (cmd_reg.ay[COORD_W-2:0] < (COORD_W-1)'(ah));

    assign xend   = {cmd_reg.ax[COORD_W-1], cmd_reg.ax} + {cmd_reg.bx[COORD_W-1], cmd_reg.bx};
    assign yend   = {cmd_reg.ay[COORD_W-1], cmd_reg.ay} + {cmd_reg.by[COORD_W-1], cmd_reg.by};
    assign abs_bx = LEN_W'(cmd_reg.bx[COORD_W-1] ? -{cmd_reg.bx[COORD_W-1], cmd_reg.bx}
                                                 : {cmd_reg.bx[COORD_W-1], cmd_reg.bx});
    assign abs_by = LEN_W'(cmd_reg.by[COORD_W-1] ? -{cmd_reg.by[COORD_W-1], cmd_reg.by}
                                                 : {cmd_reg.by[COORD_W-1], cmd_reg.by});

    // clipped bounds of the area to scan
    always_comb
    begin
        b_xs    = '0;
        b_ys    = '0;
        b_xe    = aw;
        b_ye    = ah;
        b_empty = (aw == '0) || (ah == '0);
        if (cmd_reg.op == OP_RECT)
        begin
            b_xs = cmd_reg.ax[COORD_W-1] ? '0 :
                   (cmd_reg.ax[COORD_W-2:0] > (COORD_W-1)'(aw)) ? aw :
                   DIM_W'(cmd_reg.ax[COORD_W-2:0]);
            b_ys = cmd_reg.ay[COORD_W-1] ? '0 :
                   (cmd_reg.ay[COORD_W-2:0] > (COORD_W-1)'(ah)) ? ah :
                   DIM_W'(cmd_reg.ay[COORD_W-2:0]);
            b_xe = xend[COORD_W] ? '0 :
                   (xend[COORD_W-1:0] > COORD_W'(aw)) ? aw : DIM_W'(xend[COORD_W-1:0]);
            b_ye = yend[COORD_W] ? '0 :
                   (yend[COORD_W-1:0] > COORD_W'(ah)) ? ah : DIM_W'(yend[COORD_W-1:0]);
            b_empty = cmd_reg.bx[COORD_W-1] || (cmd_reg.bx == '0)
                   || cmd_reg.by[COORD_W-1] || (cmd_reg.by == '0)
                   || (b_xs >= b_xe) || (b_ys >= b_ye);
        end
    end

    assign grid_hit  = ((yi_reg != '0) && (gy_reg == '0)) || ((xi_reg != '0) && (gx_reg == '0));
    assign scan_we   = grid_reg ? grid_hit : 1'b1;
    assign row_end   = ((cur_x_reg + DIM_W'(1)) == xe_reg);
    assign scan_last = row_end && ((cur_y_reg + DIM_W'(1)) == ye_reg);

    // frame store write port
    always_comb
    begin
        mem_we = 1'b0;
        wr_x   = cur_x_reg;
        wr_y   = cur_y_reg;
        if (state_reg == S_DISP)
        begin
            mem_we = (cmd_reg.op == OP_PIXEL) && a_in;
            wr_x   = DIM_W'(cmd_reg.ax);
            wr_y   = DIM_W'(cmd_reg.ay);
        end
        else if (state_reg == S_LDRAW)
        begin
            mem_we = line_in;
            wr_x   = DIM_W'(rx);
            wr_y   = DIM_W'(ry);
        end
        else if (state_reg == S_SCAN)
        begin
            mem_we = scan_we;
        end
    end

    assign wr_addr = {wr_y[Y_BITS-1:0], wr_x[X_BITS-1:0]};
    assign rd_addr = {cmd_reg.ay[Y_BITS-1:0], cmd_reg.ax[X_BITS-1:0]};
    assign rd_en   = (state_reg == S_DISP) && (cmd_reg.op == OP_READ);

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= cmd_reg.color;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign q_pop    = (state_reg == S_IDLE) && q_valid;
    assign out_load = (state_reg == S_DONE) && (!out_valid_reg || !rsp_stall);

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cmd_reg <= q_head;
        end
        if (state_reg == S_DISP)
        begin
            res_color_reg    <= '0;
            res_in_range_reg <= (cmd_reg.op == OP_READ) && a_in;
            xs_reg    <= b_xs;
            xe_reg    <= b_xe;
            ye_reg    <= b_ye;
            cur_x_reg <= b_xs;
            cur_y_reg <= b_ys;
            gx_reg    <= '0;
            gy_reg    <= '0;
            xi_reg    <= abs_bx;
            yi_reg    <= abs_by;
        end
        if (state_reg == S_RDW)
        begin
            res_color_reg <= res_in_range_reg ? rd_data_reg : '0;
        end
        if (state_reg == S_SCAN)
        begin
            if (row_end)
            begin
                cur_x_reg <= xs_reg;
                cur_y_reg <= cur_y_reg + DIM_W'(1);
                gx_reg    <= '0;
                gy_reg    <= ((gy_reg + LEN_W'(1)) == yi_reg) ? '0 : gy_reg + LEN_W'(1);
            end
            else
            begin
                cur_x_reg <= cur_x_reg + DIM_W'(1);
                gx_reg    <= ((gx_reg + LEN_W'(1)) == xi_reg) ? '0 : gx_reg + LEN_W'(1);
            end
        end
        if (state_reg == S_LSET)
        begin
            px_reg   <= {{2{x0[COORD_W-1]}}, x0, {FRAC_BITS{1'b0}}};
            py_reg   <= {{2{y0[COORD_W-1]}}, y0, {FRAC_BITS{1'b0}}};
            cnt_reg  <= len;
            xmaj_reg <= xmaj;
            mneg_reg <= xmaj ? dy[COORD_W] : dx[COORD_W];
            if (len == '0)
            begin
                ix_reg <= '0;
                iy_reg <= '0;
            end
            else if (xmaj)
            begin
                ix_reg <= dx[COORD_W] ? -INC_ONE : INC_ONE;
            end
            else
            begin
                iy_reg <= dy[COORD_W] ? -INC_ONE : INC_ONE;
            end
        end
        if ((state_reg == S_LDIV) && div_done)
        begin
            if (xmaj_reg)
            begin
                iy_reg <= minor_inc;
            end
            else
            begin
                ix_reg <= minor_inc;
            end
        end
        if (state_reg == S_LDRAW)
        begin
            px_reg  <= px_reg + {{(POS_W-INC_W){ix_reg[INC_W-1]}}, ix_reg};
            py_reg  <= py_reg + {{(POS_W-INC_W){iy_reg[INC_W-1]}}, iy_reg};
            cnt_reg <= cnt_reg - LEN_W'(1);
        end
        if (out_load)
        begin
            out_color_reg    <= res_color_reg;
            out_in_range_reg <= res_in_range_reg;
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            seg_reg       <= '0;
            grid_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                S_IDLE:
                begin
                    if (q_valid)
                    begin
                        state_reg <= S_DISP;
                    end
                end
                S_DISP:
                begin
                    seg_reg  <= '0;
                    grid_reg <= (cmd_reg.op == OP_GRID);
                    case (cmd_reg.op)
                        OP_LINE, OP_TRI:
                            state_reg <= S_LSET;
                        OP_CLEAR, OP_RECT, OP_GRID:
                            state_reg <= b_empty ? S_DONE : S_SCAN;
                        OP_READ:
                            state_reg <= S_RDW;
                        default:
                            state_reg <= S_DONE;
                    endcase
                end
                S_LSET:
                begin
                    state_reg <= (len == '0) ? S_LDRAW : S_LDIV;
                end
                S_LDIV:
                begin
                    if (div_done)
                    begin
                        state_reg <= S_LDRAW;
                    end
                end
                S_LDRAW:
                begin
                    if (cnt_reg == '0)
                    begin
                        if ((cmd_reg.op == OP_TRI) && (seg_reg != 2'd2))
                        begin
                            seg_reg   <= seg_reg + 2'd1;
                            state_reg <= S_LSET;
                        end
                        else
                        begin
                            state_reg <= S_DONE;
                        end
                    end
                end
                S_SCAN:
                begin
                    if (scan_last)
                    begin
                        state_reg <= S_DONE;
                    end
                end
                S_RDW:
                begin
                    state_reg <= S_DONE;
                end
                S_DONE:
                begin
                    if (out_load)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign rsp_valid  = out_valid_reg;
    assign read_color = out_color_reg;
    assign in_range   = out_in_range_reg;

`ifndef ASSERT_OFF
    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(state_reg))
        else $error("sequencer state not one-hot");

    a_write_clipped: assert property (@(posedge clk) disable iff (!rst_n)
        mem_we |-> (wr_x < aw) && (wr_y < ah))
        else $error("frame store write outside active frame");

    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg) == S_DONE)
        else $error("result raised outside completion state");
`endif

endmodule

FILE: design/raster_draw_engine.sv
// raster_draw_engine: top level of the 2D drawing engine with its frame store
// depends on rde_pkg, rde_front, rde_back (which holds rde_div)
//
// Takes one drawing command per request word and returns exactly one response
// word per command, in order. The front end buffers up to two commands, so
// new requests are taken while the back end draws. The back end writes at
// most one pixel per cycle into a 64x64 frame store, so a command's time is
// set by that single write port: clear and rectangle visit each clipped
// pixel, a grid each active-frame pixel, a line max(|dx|,|dy|)+1 points
// after setup and the minor-axis step divide (one quotient bit per cycle,
// skipped for a zero-length line), and a triangle three such lines. Every
// command also passes the fetch, dispatch and completion states, and a
// read one more state for the frame store read. Writes outside
// width_in_use/height_in_use are dropped. The frame store has no reset:
// read only pixels already written or cleared. Configuration writes are
// meant for idle periods.
module raster_draw_engine (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [rde_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [rde_pkg::DIM_W-1:0]         cfg_data,
    input  logic                              req_valid,
    output logic                              req_stall,
    input  logic [rde_pkg::REQ_W-1:0]         req_type,
    input  logic [rde_pkg::COLOR_W-1:0]       color,
    input  logic signed [rde_pkg::COORD_W-1:0] ax,
    input  logic signed [rde_pkg::COORD_W-1:0] ay,
    input  logic signed [rde_pkg::COORD_W-1:0] bx,
    input  logic signed [rde_pkg::COORD_W-1:0] by,
    input  logic signed [rde_pkg::COORD_W-1:0] cx,
    input  logic signed [rde_pkg::COORD_W-1:0] cy,
    output logic                              rsp_valid,
    input  logic                              rsp_stall,
    output logic [rde_pkg::COLOR_W-1:0]       read_color,
    output logic                              in_range
);
    import rde_pkg::*;

    // active frame size, clip limits for every write
    logic [DIM_W-1:0] width_reg;
    logic [DIM_W-1:0] height_reg;

    // command queue between front and back
    rde_cmd_t q_head;
    logic     q_valid;
    logic     q_pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= DIM_W'(64);
            height_reg <= DIM_W'(64);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_WIDTH:  width_reg  <= cfg_data;
                REG_HEIGHT: height_reg <= cfg_data;
                default:    ;
            endcase
        end
    end

    // front: request word in, decode, queue
    rde_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req_type  (req_type),
        .color     (color),
        .ax        (ax),
        .ay        (ay),
        .bx        (bx),
        .by        (by),
        .cx        (cx),
        .cy        (cy),
        .q_head    (q_head),
        .q_valid   (q_valid),
        .q_pop     (q_pop)
    );

    // back: draw into the frame store, answer with one response word
    rde_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_head        (q_head),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .width_in_use  (width_reg),
        .height_in_use (height_reg),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .read_color    (read_color),
        .in_range      (in_range)
    );

endmodule
